@@ rtl/core/ssca_pkg.sv @@
// shared constants and codes for the slab size class allocator
package ssca_pkg;

    localparam int PAGE_BYTES   = 4096;
    localparam int POOL_PAGES   = 64;
    localparam int CLASS_COUNT  = 8;
    localparam int HEADER_BYTES = 16;
    localparam int MIN_BLOCK    = 16;

    localparam int ADDR_W = 48;
    localparam int SIZE_W = 24;
    localparam int STAT_W = 2;
    localparam int TAG_W  = 12;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOP     = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOMEM   = 2'd2;
    localparam logic [STAT_W-1:0] ST_BAD_PTR = 2'd3;

    localparam logic [1:0] KIND_FREE = 2'd0;
    localparam logic [1:0] KIND_SLAB = 2'd1;
    localparam logic [1:0] KIND_HEAD = 2'd2;
    localparam logic [1:0] KIND_TAIL = 2'd3;

endpackage

@@ rtl/core/ssca_ram.sv @@
// generic simple dual-port ram with registered read
module ssca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/core/slab_size_class_allocator.sv @@
// top level of the slab size class allocator
// s_* channel (valid/ready) carries one allocate or free transaction: s_cmd,
// s_size, s_addr. m_* channel (valid/ready) returns one result per transaction:
// m_addr_out and m_status. cfg_we/cfg_wdata set the page aligned pool base;
// write it only while the block is idle.
// one transaction is worked on at a time; s_ready is high only when idle.
// path from accept to m_valid:
//   slab allocate from a non-empty list: the head's link read, the head popped
//   slab allocate with refill: pages scanned up to the first free page (one
//   per cycle), that page tagged, its blocks pushed one per cycle, then a pop
//   large allocate: pages scanned up to the end of the first fitting run,
//   then each page of the run tagged head or tail
//   free of a slab block: tag read and checked, block pushed; free of a run: tag read, each page released
//   size zero, null or out-of-pool pointer: answered without a memory access
// the page tag memory and the free-list link memory each give one read and
// one write per cycle, and the page scans walk the tag memory one entry a cycle.
// after reset a clearing pass marks every page free; s_ready stays low
// during it. a result waits in the output register while m_ready is low,
// and the next transaction is accepted meanwhile but does not finish until
// that result is taken.
module slab_size_class_allocator #(
    parameter int PAGE_BYTES  = ssca_pkg::PAGE_BYTES,
    parameter int POOL_PAGES  = ssca_pkg::POOL_PAGES,
    parameter int CLASS_COUNT = ssca_pkg::CLASS_COUNT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [ssca_pkg::ADDR_W-1:0]   cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_cmd,
    input  logic [ssca_pkg::SIZE_W-1:0]   s_size,
    input  logic [ssca_pkg::ADDR_W-1:0]   s_addr,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [ssca_pkg::ADDR_W-1:0]   m_addr_out,
    output logic [ssca_pkg::STAT_W-1:0]   m_status
);

    localparam int PGB        = $clog2(PAGE_BYTES);
    localparam int PW         = $clog2(POOL_PAGES);
    localparam int SW         = PGB - 4;
    localparam int SLOTS      = PAGE_BYTES / ssca_pkg::MIN_BLOCK;
    localparam int LINK_DEPTH = POOL_PAGES * SLOTS;
    localparam int LIW        = PW + SW;
    localparam int LW         = $clog2(LINK_DEPTH + 1);
    localparam int CW         = (CLASS_COUNT > 1) ? $clog2(CLASS_COUNT) : 1;
    localparam int NW         = PW + 2;
    localparam int KW         = (SW + 2 > NW + 1) ? SW + 2 : NW + 1;
    localparam int SMALL_MAX  = ssca_pkg::MIN_BLOCK << (CLASS_COUNT - 1);
    localparam int AW         = ssca_pkg::ADDR_W;
    localparam int TW         = ssca_pkg::TAG_W;
    localparam logic [AW-1:0] POOL_BYTES = AW'(POOL_PAGES) << PGB;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_POP_RD, S_POP_WB, S_SCAN, S_REFILL, S_PUSH,
        S_MARK, S_TAG_RD, S_TAG_CHK, S_RELEASE, S_FINISH
    } state_t;

    state_t                 state_reg;
    logic [AW-1:0]          pool_base_reg;
    logic [LW-1:0]          head_reg [CLASS_COUNT];
    logic [CW-1:0]          cls_reg;
    logic [NW-1:0]          n_reg;
    logic [PW-1:0]          page_reg;
    logic [PGB-1:0]         in_page_reg;
    logic [KW-1:0]          k_reg;
    logic [PW:0]            scan_reg;
    logic [PW-1:0]          chk_idx_reg;
    logic                   chk_vld_reg;
    logic [NW-1:0]          run_reg;
    logic [PW:0]            clr_reg;
    logic                   large_req_reg;
    logic [AW-1:0]          res_addr_reg;
    logic [ssca_pkg::STAT_W-1:0] res_status_reg;
    logic                   m_valid_reg;
    logic [AW-1:0]          m_addr_out_reg;
    logic [ssca_pkg::STAT_W-1:0] m_status_reg;

    logic          tag_we;
    logic [PW-1:0] tag_waddr;
    logic [TW-1:0] tag_wdata;
    logic [PW-1:0] tag_raddr;
    logic [TW-1:0] tag_rdata;
    logic           link_we;
    logic [LIW-1:0] link_waddr;
    logic [LW-1:0]  link_wdata;
    logic [LIW-1:0] link_raddr;
    logic [LW-1:0]  link_rdata;

    // decode of the incoming transaction
    logic [CW-1:0] cls_in;
    logic [25:0]   nsum;
    logic [25:0]   nbig;
    logic [AW-1:0] off_in;
    always_comb begin
        cls_in = CW'(CLASS_COUNT - 1);
        for (int j = CLASS_COUNT - 1; j >= 0; j--) begin
            if ((32'(ssca_pkg::MIN_BLOCK) << j) >= 32'(s_size)) begin
                cls_in = CW'(j);
            end
        end
        nsum   = 26'(s_size) + 26'(ssca_pkg::HEADER_BYTES + PAGE_BYTES - 1);
        nbig   = nsum >> PGB;
        off_in = s_addr - pool_base_reg;
    end

    // free check on the page tag
    logic [1:0]     tag_kind;
    logic [CW-1:0]  tag_cls;
    logic [PGB-1:0] rel;
    logic [PGB:0]   bsz;
    logic           slab_ok;
    logic [LIW-1:0] slot;
    always_comb begin
        tag_kind = tag_rdata[TW-1:TW-2];
        tag_cls  = tag_rdata[CW-1:0];
        rel      = in_page_reg - PGB'(ssca_pkg::HEADER_BYTES);
        bsz      = (PGB+1)'(ssca_pkg::MIN_BLOCK) << tag_cls;
        slab_ok  = (tag_kind == ssca_pkg::KIND_SLAB)
                && (32'(tag_rdata[9:0]) < 32'(CLASS_COUNT))
                && (in_page_reg >= PGB'(ssca_pkg::HEADER_BYTES))
                && (((PGB+1)'(rel) & (bsz - 1'b1)) == '0)
                && ((PGB+1)'(rel) + bsz
                    <= (PGB+1)'(PAGE_BYTES - ssca_pkg::HEADER_BYTES));
        slot     = {page_reg, rel[PGB-1:4]};
    end

    logic [KW-1:0] step;
    assign step = KW'(1) << cls_reg;

    always_comb begin
        tag_we     = 1'b0;
        tag_waddr  = page_reg;
        tag_wdata  = '0;
        tag_raddr  = scan_reg[PW-1:0];
        link_we    = 1'b0;
        link_waddr = {page_reg, k_reg[SW-1:0]};
        link_wdata = head_reg[cls_reg];
        link_raddr = LIW'(head_reg[cls_reg] - 1'b1);
        case (state_reg)
            S_CLEAR: begin
                tag_we    = 1'b1;
                tag_waddr = clr_reg[PW-1:0];
            end
            S_TAG_RD: tag_raddr = page_reg;
            S_REFILL: begin
                tag_we    = 1'b1;
                tag_wdata = {ssca_pkg::KIND_SLAB, 10'(cls_reg)};
            end
            S_PUSH: link_we = 1'b1;
            S_MARK: begin
                tag_we    = 1'b1;
                tag_waddr = PW'(KW'(page_reg) + k_reg);
                tag_wdata = (k_reg == '0) ? {ssca_pkg::KIND_HEAD, 10'(n_reg - 1'b1)}
                                          : {ssca_pkg::KIND_TAIL, 10'd0};
            end
            S_TAG_CHK: begin
                link_we    = slab_ok;
                link_waddr = slot;
                link_wdata = head_reg[tag_cls];
            end
            S_RELEASE: begin
                tag_we    = 1'b1;
                tag_waddr = PW'(KW'(page_reg) + k_reg);
            end
            default: ;
        endcase
    end

    ssca_ram #(.WIDTH(TW), .DEPTH(POOL_PAGES)) u_tag_ram (
        .aclk  (aclk),
        .we    (tag_we),
        .waddr (tag_waddr),
        .wdata (tag_wdata),
        .raddr (tag_raddr),
        .rdata (tag_rdata)
    );

    ssca_ram #(.WIDTH(LW), .DEPTH(LINK_DEPTH)) u_link_ram (
        .aclk  (aclk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .raddr (link_raddr),
        .rdata (link_rdata)
    );

    logic [NW-1:0] run_inc;
    assign run_inc = run_reg + 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            pool_base_reg <= '0;
            m_valid_reg   <= 1'b0;
            for (int i = 0; i < CLASS_COUNT; i++) begin
                head_reg[i] <= '0;
            end
        end else begin
            if (cfg_we) begin
                pool_base_reg <= cfg_wdata;
            end
            if (m_valid_reg && m_ready && state_reg != S_FINISH) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLEAR: begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == (PW+1)'(POOL_PAGES - 1)) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_valid) begin
                        cls_reg        <= cls_in;
                        page_reg       <= off_in[PGB +: PW];
                        in_page_reg    <= off_in[PGB-1:0];
                        large_req_reg  <= 32'(s_size) > 32'(SMALL_MAX);
                        res_addr_reg   <= '0;
                        res_status_reg <= ssca_pkg::ST_OK;
                        scan_reg       <= '0;
                        chk_vld_reg    <= 1'b0;
                        run_reg        <= '0;
                        k_reg          <= '0;
                        if (s_cmd == ssca_pkg::CMD_ALLOC) begin
                            if (s_size == '0) begin
                                res_status_reg <= ssca_pkg::ST_NOP;
                                state_reg      <= S_FINISH;
                            end else if (32'(s_size) <= 32'(SMALL_MAX)) begin
                                n_reg     <= NW'(1);
                                state_reg <= (head_reg[cls_in] != '0) ? S_POP_RD : S_SCAN;
                            end else if (nbig > 26'(POOL_PAGES)) begin
                                res_status_reg <= ssca_pkg::ST_NOMEM;
                                state_reg      <= S_FINISH;
                            end else begin
                                n_reg     <= NW'(nbig);
                                state_reg <= S_SCAN;
                            end
                        end else begin
                            if (s_addr == '0) begin
                                res_status_reg <= ssca_pkg::ST_NOP;
                                state_reg      <= S_FINISH;
                            end else if (off_in >= POOL_BYTES) begin
                                res_status_reg <= ssca_pkg::ST_BAD_PTR;
                                state_reg      <= S_FINISH;
                            end else begin
                                state_reg <= S_TAG_RD;
                            end
                        end
                    end
                end
                S_POP_RD: state_reg <= S_POP_WB;
                S_POP_WB: begin
                    head_reg[cls_reg] <= link_rdata;
                    res_addr_reg      <= pool_base_reg + (AW'(head_reg[cls_reg]) << 4);
                    state_reg         <= S_FINISH;
                end
                S_SCAN: begin
                    if (scan_reg < (PW+1)'(POOL_PAGES)) begin
                        scan_reg <= scan_reg + 1'b1;
                    end
                    chk_vld_reg <= scan_reg < (PW+1)'(POOL_PAGES);
                    chk_idx_reg <= scan_reg[PW-1:0];
                    if (chk_vld_reg) begin
                        if (tag_rdata == '0) begin
                            run_reg <= run_inc;
                        end else begin
                            run_reg <= '0;
                        end
                        if (tag_rdata == '0 && run_inc == n_reg) begin
                            page_reg  <= PW'(NW'(chk_idx_reg) - (n_reg - 1'b1));
                            state_reg <= large_req_reg ? S_MARK : S_REFILL;
                        end else if (chk_idx_reg == PW'(POOL_PAGES - 1)) begin
                            res_status_reg <= ssca_pkg::ST_NOMEM;
                            state_reg      <= S_FINISH;
                        end
                    end
                end
                S_REFILL: begin
                    k_reg     <= '0;
                    state_reg <= S_PUSH;
                end
                S_PUSH: begin
                    head_reg[cls_reg] <= LW'({page_reg, k_reg[SW-1:0]}) + 1'b1;
                    k_reg             <= k_reg + step;
                    if (k_reg + (step << 1) > KW'(SLOTS - 1)) begin
                        state_reg <= S_POP_RD;
                    end
                end
                S_MARK: begin
                    k_reg <= k_reg + 1'b1;
                    if (k_reg == KW'(n_reg - 1'b1)) begin
                        res_addr_reg <= pool_base_reg + (AW'(page_reg) << PGB)
                                        + AW'(ssca_pkg::HEADER_BYTES);
                        state_reg    <= S_FINISH;
                    end
                end
                S_TAG_RD: state_reg <= S_TAG_CHK;
                S_TAG_CHK: begin
                    if (tag_kind == ssca_pkg::KIND_HEAD) begin
                        if (in_page_reg != PGB'(ssca_pkg::HEADER_BYTES)) begin
                            res_status_reg <= ssca_pkg::ST_BAD_PTR;
                            state_reg      <= S_FINISH;
                        end else begin
                            n_reg     <= NW'(11'(tag_rdata[9:0]) + 11'd1);
                            k_reg     <= '0;
                            state_reg <= S_RELEASE;
                        end
                    end else if (slab_ok) begin
                        head_reg[tag_cls] <= LW'(slot) + 1'b1;
                        state_reg         <= S_FINISH;
                    end else begin
                        res_status_reg <= ssca_pkg::ST_BAD_PTR;
                        state_reg      <= S_FINISH;
                    end
                end
                S_RELEASE: begin
                    k_reg <= k_reg + 1'b1;
                    if (k_reg + 1'b1 == KW'(n_reg)
                            || KW'(page_reg) + k_reg + 1'b1 >= KW'(POOL_PAGES)) begin
                        state_reg <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg    <= 1'b1;
                        m_addr_out_reg <= res_addr_reg;
                        m_status_reg   <= res_status_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_ready    = (state_reg == S_IDLE);
    assign m_valid    = m_valid_reg;
    assign m_addr_out = m_addr_out_reg;
    assign m_status   = m_status_reg;

endmodule

@@ rtl/core/ssca_checker.sv @@
// port level checks for the slab size class allocator, bound to the top level
module ssca_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_valid,
    input logic                        s_ready,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [ssca_pkg::ADDR_W-1:0] m_addr_out,
    input logic [ssca_pkg::STAT_W-1:0] m_status
);

    // no result right after reset
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // a stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_addr_out) && $stable(m_status))
        else $error("stalled result changed");

    // failed or empty transactions carry a null address
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ssca_pkg::ST_OK |-> m_addr_out == '0)
        else $error("non-null address with failure status");

    // one transaction in work at a time
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second transaction accepted while busy");

endmodule

bind slab_size_class_allocator ssca_checker u_ssca_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .s_valid    (s_valid),
    .s_ready    (s_ready),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_addr_out (m_addr_out),
    .m_status   (m_status)
);

@@ tb/tb_slab_size_class_allocator.sv @@
// testbench for the slab size class allocator, checked against a predictor
module tb_slab_size_class_allocator;
    import ssca_pkg::*;

    localparam int LINK_DEPTH = POOL_PAGES * PAGE_BYTES / MIN_BLOCK;
    localparam int SETTLE     = 600;
    localparam int LIMIT      = 2000000;
    localparam logic [ADDR_W-1:0] TOP_BASE = 48'hFFFF_FFFF_F000;

    typedef enum logic [1:0] {EK_REQ, EK_FREE_LIVE, EK_CFG, EK_DRAIN} entry_kind_t;

    typedef struct {
        entry_kind_t       kind;
        logic              cmd;
        logic [SIZE_W-1:0] size;
        logic [ADDR_W-1:0] addr;
        bit                keep;
    } entry_t;

    typedef struct {
        logic [ADDR_W-1:0] addr_out;
        logic [STAT_W-1:0] status;
    } result_t;

    logic              aclk = 0;
    logic              aresetn = 0;
    logic              cfg_we = 0;
    logic [ADDR_W-1:0] cfg_wdata = '0;
    logic              s_valid = 0;
    logic              s_ready;
    logic              s_cmd = 0;
    logic [SIZE_W-1:0] s_size = '0;
    logic [ADDR_W-1:0] s_addr = '0;
    logic              m_valid;
    logic              m_ready = 0;
    logic [ADDR_W-1:0] m_addr_out;
    logic [STAT_W-1:0] m_status;

    slab_size_class_allocator i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_cmd     (s_cmd),
        .s_size    (s_size),
        .s_addr    (s_addr),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_addr_out(m_addr_out),
        .m_status  (m_status)
    );

    // predicted allocator state
    logic [ADDR_W-1:0] pool_base_q = '0;
    logic [TAG_W-1:0]  page_tag [POOL_PAGES];
    logic [14:0]       block_link [LINK_DEPTH];
    logic [14:0]       class_head [CLASS_COUNT];
    logic [13:0]       class_used [CLASS_COUNT];

    entry_t            pending_reqs [$];
    result_t           expected_results [$];
    logic [ADDR_W-1:0] live_offsets [$];
    entry_t            cur;
    int                hold = 0;
    int                n_accepted = 0;
    int                errors = 0;
    int                cycles = 0;

    initial begin
        forever #10 aclk = ~aclk;
    end

    initial begin
        foreach (page_tag[i]) page_tag[i] = '0;
        foreach (block_link[i]) block_link[i] = '0;
        foreach (class_head[i]) class_head[i] = '0;
        foreach (class_used[i]) class_used[i] = '0;
    end

    function automatic int first_free_run(int n);
        int run;
        run = 0;
        for (int p = 0; p < POOL_PAGES; p++) begin
            run = (page_tag[p] == '0) ? run + 1 : 0;
            if (run == n) return p - n + 1;
        end
        return -1;
    endfunction

    task automatic serve_alloc(input logic [SIZE_W-1:0] size, output result_t r);
        int c, p, n, id, bsize;
        logic [ADDR_W-1:0] off;
        r.addr_out = '0;
        r.status = ST_OK;
        if (size == 0) begin
            r.status = ST_NOP;
        end else if (size <= (MIN_BLOCK << (CLASS_COUNT - 1))) begin
            c = 0;
            while (c < CLASS_COUNT - 1 && (MIN_BLOCK << c) < size) c++;
            if (class_head[c] == 0) begin
                p = first_free_run(1);
                if (p < 0) begin
                    r.status = ST_NOMEM;
                    return;
                end
                bsize = MIN_BLOCK << c;
                page_tag[p] = {KIND_SLAB, 10'(c)};
                for (int i = 0; i < (PAGE_BYTES - HEADER_BYTES) / bsize; i++) begin
                    id = p * (PAGE_BYTES / MIN_BLOCK) + i * bsize / MIN_BLOCK;
                    block_link[id] = class_head[c];
                    class_head[c] = 15'(id + 1);
                end
            end
            id = (int'(class_head[c]) - 1) % LINK_DEPTH;
            class_head[c] = block_link[id];
            class_used[c] = class_used[c] + 1'b1;
            off = ADDR_W'((id / (PAGE_BYTES / MIN_BLOCK)) * PAGE_BYTES + HEADER_BYTES
                + (id % (PAGE_BYTES / MIN_BLOCK)) * MIN_BLOCK);
            live_offsets.push_back(off);
            r.addr_out = pool_base_q + off;
        end else begin
            n = (int'(size) + HEADER_BYTES + PAGE_BYTES - 1) / PAGE_BYTES;
            p = (n > POOL_PAGES) ? -1 : first_free_run(n);
            if (p < 0) begin
                r.status = ST_NOMEM;
                return;
            end
            page_tag[p] = {KIND_HEAD, 10'(n - 1)};
            for (int i = 1; i < n; i++) page_tag[p + i] = {KIND_TAIL, 10'd0};
            off = ADDR_W'(p * PAGE_BYTES + HEADER_BYTES);
            live_offsets.push_back(off);
            r.addr_out = pool_base_q + off;
        end
    endtask

    task automatic serve_free(input logic [ADDR_W-1:0] addr, output result_t r);
        logic [ADDR_W-1:0] off;
        logic [TAG_W-1:0] tag;
        int p, in_page, c, bsize, slot, n;
        r.addr_out = '0;
        r.status = ST_OK;
        if (addr == 0) begin
            r.status = ST_NOP;
            return;
        end
        off = addr - pool_base_q;
        if (off >= POOL_PAGES * PAGE_BYTES) begin
            r.status = ST_BAD_PTR;
            return;
        end
        p = int'(off) / PAGE_BYTES;
        in_page = int'(off) % PAGE_BYTES;
        tag = page_tag[p];
        if (tag[11:10] == KIND_HEAD) begin
            n = int'(tag[9:0]) + 1;
            if (in_page != HEADER_BYTES) begin
                r.status = ST_BAD_PTR;
                return;
            end
            for (int i = 0; i < n && p + i < POOL_PAGES; i++) page_tag[p + i] = '0;
            return;
        end
        if (tag[11:10] != KIND_SLAB || int'(tag[9:0]) >= CLASS_COUNT) begin
            r.status = ST_BAD_PTR;
            return;
        end
        c = int'(tag[9:0]);
        bsize = MIN_BLOCK << c;
        if (in_page < HEADER_BYTES || (in_page - HEADER_BYTES) % bsize != 0
            || (in_page - HEADER_BYTES) / bsize
               >= (PAGE_BYTES - HEADER_BYTES) / bsize) begin
            r.status = ST_BAD_PTR;
            return;
        end
        slot = p * (PAGE_BYTES / MIN_BLOCK) + (in_page - HEADER_BYTES) / MIN_BLOCK;
        block_link[slot] = class_head[c];
        class_head[c] = 15'(slot + 1);
        class_used[c] = class_used[c] - 1'b1;
    endtask

    // driver
    always @(posedge aclk) begin
        logic v, we;
        result_t r;
        int idx;
        if (!aresetn) begin
            s_valid <= 1'b0;
            cfg_we <= 1'b0;
        end else begin
            v = s_valid;
            we = 1'b0;
            if (s_valid && s_ready) begin
                if (s_cmd == CMD_ALLOC) serve_alloc(s_size, r);
                else serve_free(s_addr, r);
                expected_results.push_back(r);
                n_accepted++;
                v = 1'b0;
            end
            if (!v) begin
                if (hold > 0) begin
                    hold--;
                end else if (pending_reqs.size() > 0) begin
                    cur = pending_reqs[0];
                    case (cur.kind)
                        EK_DRAIN: begin
                            if (expected_results.size() == 0) begin
                                void'(pending_reqs.pop_front());
                                hold = SETTLE;
                            end
                        end
                        EK_CFG: begin
                            void'(pending_reqs.pop_front());
                            we = 1'b1;
                            cfg_wdata <= cur.addr;
                            pool_base_q = cur.addr;
                        end
                        default: begin
                            if ((n_accepted >= 300 && n_accepted < 420)
                                || $urandom_range(99) >= 19) begin
                                void'(pending_reqs.pop_front());
                                if (cur.kind == EK_FREE_LIVE) begin
                                    if (live_offsets.size() == 0) begin
                                        cur.cmd = CMD_ALLOC;
                                        cur.size = SIZE_W'($urandom_range(1, 64));
                                    end else begin
                                        idx = $urandom_range(live_offsets.size() - 1);
                                        cur.addr = pool_base_q + live_offsets[idx] + cur.addr;
                                        if (!cur.keep) live_offsets.delete(idx);
                                    end
                                end
                                s_cmd <= cur.cmd;
                                s_size <= cur.size;
                                s_addr <= cur.addr;
                                v = 1'b1;
                            end
                        end
                    endcase
                end
            end
            s_valid <= v;
            cfg_we <= we;
        end
    end

    // receiver stalls and result check
    always @(posedge aclk) begin
        result_t e;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected transaction addr_out=%h status=%0d",
                           m_addr_out, m_status);
                    errors++;
                end else begin
                    e = expected_results.pop_front();
                    if (m_addr_out !== e.addr_out) begin
                        $error("addr_out expected %h actual %h", e.addr_out, m_addr_out);
                        errors++;
                    end
                    if (m_status !== e.status) begin
                        $error("status expected %0d actual %0d", e.status, m_status);
                        errors++;
                    end
                end
            end
            m_ready <= (n_accepted >= 300 && n_accepted < 420) || $urandom_range(99) >= 19;
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("tb_slab_size_class_allocator failed");
            $finish;
        end
    end

    function automatic entry_t req(logic cmd, logic [SIZE_W-1:0] size, logic [ADDR_W-1:0] addr);
        entry_t e;
        e.kind = EK_REQ;
        e.cmd = cmd;
        e.size = size;
        e.addr = addr;
        e.keep = 0;
        return e;
    endfunction

    task automatic push_free_live(logic [ADDR_W-1:0] tweak, bit keep);
        entry_t e;
        e = req(CMD_FREE, SIZE_W'($urandom), tweak);
        e.kind = EK_FREE_LIVE;
        e.keep = keep;
        pending_reqs.push_back(e);
    endtask

    task automatic push_cfg(logic [ADDR_W-1:0] base);
        entry_t e;
        e = req(CMD_ALLOC, '0, base);
        e.kind = EK_DRAIN;
        pending_reqs.push_back(e);
        e.kind = EK_CFG;
        pending_reqs.push_back(e);
    endtask

    task automatic push_random(int count);
        int r, c, n;
        logic [ADDR_W-1:0] tweak;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(99);
            if (r < 45) begin
                c = $urandom_range(CLASS_COUNT - 1);
                pending_reqs.push_back(req(CMD_ALLOC,
                    SIZE_W'($urandom_range(MIN_BLOCK << c, c == 0 ? 1 : (8 << c) + 1)),
                    {$urandom, $urandom}));
            end else if (r < 55) begin
                n = ($urandom_range(9) == 0) ? $urandom_range(POOL_PAGES + 1, 4)
                                             : $urandom_range(3, 1);
                pending_reqs.push_back(req(CMD_ALLOC,
                    SIZE_W'($urandom_range(n * PAGE_BYTES - HEADER_BYTES,
                        n == 1 ? 2049 : (n - 1) * PAGE_BYTES - HEADER_BYTES + 1)),
                    {$urandom, $urandom}));
            end else if (r < 88) begin
                case ($urandom_range(9))
                    0: tweak = ADDR_W'($urandom_range(15, 1));
                    1: tweak = {$urandom, $urandom};
                    default: tweak = '0;
                endcase
                push_free_live(tweak, $urandom_range(19) == 0);
            end else if (r < 92) begin
                pending_reqs.push_back(req(r[0] ? CMD_FREE : CMD_ALLOC, '0, '0));
            end else if (r < 96) begin
                pending_reqs.push_back(req(CMD_FREE, SIZE_W'($urandom), {$urandom, $urandom}));
            end else begin
                pending_reqs.push_back(req(CMD_ALLOC, SIZE_W'($urandom), {$urandom, $urandom}));
            end
        end
    endtask

    initial begin
        push_cfg('0);
        pending_reqs.push_back(req(CMD_ALLOC, '0, '0));
        for (int c = 0; c < CLASS_COUNT; c++) begin
            pending_reqs.push_back(req(CMD_ALLOC,
                SIZE_W'((MIN_BLOCK << c) - (c == 0 ? 15 : 0)), '0));
        end
        pending_reqs.push_back(req(CMD_ALLOC, 24'd17, '1));
        pending_reqs.push_back(req(CMD_ALLOC, 24'd2049, '0));
        pending_reqs.push_back(req(CMD_ALLOC, 24'd4081, '0));
        push_free_live(48'd4096, 1'b1);
        push_free_live(48'd8, 1'b1);
        push_free_live(48'd16, 1'b1);
        pending_reqs.push_back(req(CMD_ALLOC, '1, '0));
        pending_reqs.push_back(req(CMD_FREE, '1, '0));
        pending_reqs.push_back(req(CMD_FREE, '0, 48'h8000_0000_0000));
        pending_reqs.push_back(req(CMD_FREE, '0, 48'(63 * PAGE_BYTES + HEADER_BYTES)));
        pending_reqs.push_back(req(CMD_FREE, '0, 48'(PAGE_BYTES)));
        push_free_live('0, 1'b1);
        push_free_live('0, 1'b0);
        push_free_live('0, 1'b0);
        push_cfg({$urandom, $urandom} & TOP_BASE);
        push_random(230);
        push_cfg(TOP_BASE);
        push_random(230);
        push_cfg('0);
        push_random(230);

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        do @(posedge aclk);
        while (pending_reqs.size() != 0 || s_valid || expected_results.size() != 0);
        repeat (SETTLE) @(posedge aclk);
        if (expected_results.size() != 0) begin
            $error("%0d results never arrived", expected_results.size());
            errors++;
        end
        if (errors == 0) begin
            $display("tb_slab_size_class_allocator passed");
        end else begin
            $display("tb_slab_size_class_allocator failed");
        end
        $finish;
    end

endmodule
